FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/wlh_pkg.sv
package wlh_pkg;

	localparam int CNT_W   = 24;
	localparam int SCALE_W = 6;
	localparam int PROD_W  = CNT_W + SCALE_W;
	localparam int QBIT_W  = $clog2(SCALE_W);

	localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};
	localparam logic [SCALE_W-1:0] SCALE_RESET = 6'd5;

	localparam logic OP_CHAR   = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_TAB     = 8'h09;

	typedef struct packed {
		logic       opcode;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic [3:0]         word_length;
		logic [CNT_W-1:0]   word_count;
		logic [SCALE_W-1:0] bar_length;
		logic [CNT_W-1:0]   overflow_words;
		logic               last_row;
	} result_t;

	function automatic logic is_separator(input logic [7:0] ch);
		return (ch == CHAR_SPACE) || (ch == CHAR_NEWLINE) || (ch == CHAR_TAB);
	endfunction

endpackage

FILE: rtl/word_length_histogram.sv
// Word length histogram. Character requests are taken one per cycle; a separator
// that closes a word of length 1 to MAX_LEN-1 holds busy for one extra cycle while
// the histogram RAM entry is read, incremented and written back. A report request
// keeps busy high for 9*(MAX_LEN-1) cycles: each row needs a RAM read, a multiply
// of count by bar_scale and six steps of the shared restoring divider, which
// yields one bar bit per cycle. Rows appear with result_valid high for one cycle,
// one row every ninth cycle, and the receiver cannot stall them, so it must take
// each row when it is shown. The counts are cleared right after the last row;
// valid bits stand in for clearing the RAM, so no clearing pass follows reset.
`include "assert_macros.svh"

module word_length_histogram
	import wlh_pkg::*;
#(
	parameter int MAX_LEN = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  req_t               req,
	input  logic               cfg_we,
	input  logic [SCALE_W-1:0] cfg_data,
	output logic               result_valid,
	output result_t            result
);

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = $clog2(MAX_LEN);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_UPD  = 6'b000010,
		ST_READ = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t              state_q;
	logic                in_word_q;
	logic [LEN_W-1:0]    cur_len_q;
	logic [MAX_LEN-1:0]  valid_q;
	logic [CNT_W-1:0]    overflow_q;
	logic [CNT_W-1:0]    peak_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [ADDR_W-1:0]   row_q;
	logic [QBIT_W-1:0]   bit_q;

	logic                rd_valid_q;
	logic [ADDR_W-1:0]   upd_addr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   rem_q;
	logic [SCALE_W-1:0]  quo_q;

	logic                accept;
	logic                is_sep;
	logic                len_short;
	logic                ram_re;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [CNT_W-1:0]    ram_rdata;
	logic [CNT_W-1:0]    cnt_rd;
	logic [CNT_W-1:0]    cnt_inc;
	logic [PROD_W-1:0]   div_step;
	logic                div_ge;
	logic                last_row;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign is_sep    = is_separator(req.char_code);
	assign len_short = (cur_len_q < LEN_W'(MAX_LEN));
	assign last_row  = (row_q == ADDR_W'(MAX_LEN - 1));

	// Entries never written since the last clear read as zero.
	assign cnt_rd  = rd_valid_q ? ram_rdata : '0;
	assign cnt_inc = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + CNT_W'(1);

	assign ram_raddr = (state_q == ST_IDLE) ? cur_len_q[ADDR_W-1:0] : row_q;
	assign ram_re    = (accept && req.opcode == OP_CHAR && is_sep &&
		cur_len_q != '0 && len_short) || (state_q == ST_READ);
	assign ram_we    = (state_q == ST_UPD);

	// The quotient never exceeds bar_scale, since no count exceeds the peak.
	assign div_step = PROD_W'(peak_q) << bit_q;
	assign div_ge   = (rem_q >= div_step);

	wlh_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_LEN)
	) u_hist_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(upd_addr_q),
		.wdata(cnt_inc),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_word_q  <= 1'b0;
			cur_len_q  <= '0;
			valid_q    <= '0;
			overflow_q <= '0;
			peak_q     <= '0;
			scale_q    <= SCALE_RESET;
			row_q      <= '0;
			bit_q      <= '0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.opcode == OP_REPORT) begin
							row_q   <= ADDR_W'(1);
							state_q <= ST_READ;
						end else if (is_sep) begin
							if (cur_len_q != '0) begin
								if (len_short) begin
									state_q <= ST_UPD;
								end else if (overflow_q != CNT_MAX) begin
									overflow_q <= overflow_q + CNT_W'(1);
								end
							end
							cur_len_q <= '0;
							in_word_q <= 1'b0;
						end else if (!in_word_q) begin
							in_word_q <= 1'b1;
							cur_len_q <= LEN_W'(1);
						end else if (len_short) begin
							cur_len_q <= cur_len_q + LEN_W'(1);
						end
					end
				end
				ST_UPD: begin
					valid_q[upd_addr_q] <= 1'b1;
					if (cnt_inc > peak_q) begin
						peak_q <= cnt_inc;
					end
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					bit_q   <= QBIT_W'(SCALE_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						bit_q <= bit_q - QBIT_W'(1);
					end
				end
				ST_EMIT: begin
					if (last_row) begin
						// An open word is dropped along with the counts.
						in_word_q  <= 1'b0;
						cur_len_q  <= '0;
						valid_q    <= '0;
						overflow_q <= '0;
						peak_q     <= '0;
						state_q    <= ST_IDLE;
					end else begin
						row_q   <= row_q + ADDR_W'(1);
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_valid_q <= valid_q[ram_raddr];
		end
		if (accept) begin
			upd_addr_q <= cur_len_q[ADDR_W-1:0];
		end
		if (state_q == ST_MUL) begin
			cnt_q <= cnt_rd;
			rem_q <= PROD_W'(cnt_rd) * PROD_W'(scale_q);
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			quo_q[bit_q] <= div_ge;
			if (div_ge) begin
				rem_q <= rem_q - div_step;
			end
		end
	end

	always_comb begin
		result_valid          = (state_q == ST_EMIT);
		result.word_length    = 4'(row_q);
		result.word_count     = cnt_q;
		result.overflow_words = overflow_q;
		result.last_row       = last_row;
		if (cnt_q == '0) begin
			result.bar_length = '0;
		end else if (quo_q == '0) begin
			result.bar_length = SCALE_W'(1);
		end else begin
			result.bar_length = quo_q;
		end
	end

	`ASSERT_NEXT(a_last_row_idle, clk, arst_n, result_valid && result.last_row, !busy)
	`ASSERT_IMPL(a_bar_zero, clk, arst_n, result_valid, (result.word_count == '0) == (result.bar_length == '0))
	`ASSERT_NEXT(a_report_busy, clk, arst_n, accept && req.opcode == OP_REPORT, busy)
	`ASSERT_NEXT(a_rows_spaced, clk, arst_n, result_valid, !result_valid)
	`ASSERT_IMPL(a_cnt_le_peak, clk, arst_n, state_q == ST_DIV, cnt_q <= peak_q)

endmodule

FILE: rtl/wlh_ram.sv
module wlh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
